// ----- design/flog2_pkg.sv -----
// Shared constants, a type and a helper function for the fast log2 approximation core.
package flog2_pkg;

	// Field widths of the input and result beats.
	localparam int IN_W  = 32;
	localparam int OUT_W = 26;

	// Output format and the rounding shift from the Q30 working format.
	localparam int OUT_FRAC_BITS = 16;
	localparam int WORK_FRAC     = 30;
	localparam int RND_SHIFT     = WORK_FRAC - OUT_FRAC_BITS;

	// Internal widths.
	localparam int MANT_W  = 24;                // hidden one plus 23 mantissa bits
	localparam int M_W     = 30;                // m in Q30, always below 1.0
	localparam int PROD_W  = 55;                // K1 times the 24-bit mantissa
	localparam int D_W     = 31;                // divisor K3 + m
	localparam int REM_W   = 31;                // partial remainder, always below the divisor
	localparam int Q_W     = 32;                // quotient bits, one per cell
	localparam int NUM_W   = 62;                // dividend K2 * 2^30 + floor(d / 2)
	localparam int ACC_W   = 42;                // signed running sum in Q30
	localparam int NCELLS  = Q_W;

	// Coefficients in Q30, rounded to nearest at elaboration.
	localparam logic [127:0] K0_WIDE =
		((128'd12422551499 << 30) + 128'd50000000) / 128'd100000000;
	localparam logic [127:0] K1_WIDE =
		((128'd1498030302 << 30) + 128'd500000000) / 128'd1000000000;
	localparam logic [127:0] K2_WIDE =
		((128'd172587999 << 30) + 128'd50000000) / 128'd100000000;
	localparam logic [127:0] K3_WIDE =
		((128'd3520887068 << 30) + 128'd5000000000) / 128'd10000000000;

	localparam logic [ACC_W-1:0] K0 = K0_WIDE[ACC_W-1:0];
	localparam logic [30:0]      K1 = K1_WIDE[30:0];
	localparam logic [30:0]      K2 = K2_WIDE[30:0];
	localparam logic [D_W-1:0]   K3 = K3_WIDE[D_W-1:0];

	// Half of one output step, added before the final shift so that it rounds.
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);
	// Half of one unit of the product's discarded 24 bits.
	localparam logic [PROD_W-1:0] PROD_HALF =
		PROD_W'(1) << (WORK_FRAC - (M_W - MANT_W) - 1);

	// Saturation bounds of the result field.
	localparam logic signed [ACC_W-1:0] OUT_MAX_A = ACC_W'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic signed [ACC_W-1:0] OUT_MIN_A = -(ACC_W'(64'd1 << (OUT_W - 1)));

	// Data carried from one divider cell to the next.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   num;
		logic [D_W-1:0]   den;
		logic [Q_W-1:0]   quo;
		logic [ACC_W-1:0] acc;
	} cell_t;

	// Clamp a shifted result to the output field.
	function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] val);
		logic [OUT_W-1:0] res;
		if (val > OUT_MAX_A) begin
			res = OUT_MAX_A[OUT_W-1:0];
		end else if (val < OUT_MIN_A) begin
			res = OUT_MIN_A[OUT_W-1:0];
		end else begin
			res = val[OUT_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- design/flog2_front.sv -----
// Front end: product, offset sum and divisor set-up ahead of the divider chain.
module flog2_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           vld_in,
	input  logic [flog2_pkg::IN_W-1:0]     float_bits,
	output logic                           vld_out,
	output flog2_pkg::cell_t               cell_out
);
	import flog2_pkg::*;

	logic [MANT_W-1:0] mant;
	logic [M_W-1:0]    m_val;
	logic [ACC_W-1:0]  y_val;
	logic [PROD_W-1:0] prod_rnd;
	logic [NUM_W-1:0]  num;

	logic              vld_s1, vld_s2, vld_s3;
	logic [PROD_W-1:0] prod_s1;
	logic [ACC_W-1:0]  c_s1, c_s2;
	logic [D_W-1:0]    d_s1, d_s2, d_s3;
	logic [30:0]       p_s2;
	logic [ACC_W-1:0]  acc_s3;

	// Mantissa with the exponent of one half, and the raw pattern scaled to Q30.
	assign mant     = {1'b1, float_bits[22:0]};
	assign m_val    = {mant, 6'b0};
	assign y_val    = {3'b0, float_bits, 7'b0};
	assign prod_rnd = prod_s1 + PROD_HALF;

	// Valid bits move with the pipeline enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage one multiplies, stage two rounds the product, stage three forms the sum.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(K1) * PROD_W'(mant);
			c_s1    <= y_val - K0 + RND_HALF;
			d_s1    <= K3 + D_W'(m_val);
			p_s2    <= prod_rnd[PROD_W-1:PROD_W-31];
			c_s2    <= c_s1;
			d_s2    <= d_s1;
			acc_s3  <= c_s2 - ACC_W'(p_s2);
			d_s3    <= d_s2;
		end
	end

	// Dividend K2 * 2^30 + floor(d / 2); the low 30 bits of K2 * 2^30 are zero.
	assign num = {1'b0, K2, d_s3[D_W-1:1]};

	// The part above the quotient bits seeds the remainder.
	assign vld_out       = vld_s3;
	assign cell_out.rem  = REM_W'(num[NUM_W-1:Q_W]);
	assign cell_out.num  = num[Q_W-1:0];
	assign cell_out.den  = d_s3;
	assign cell_out.quo  = '0;
	assign cell_out.acc  = acc_s3;

endmodule

// ----- design/flog2_cell.sv -----
// One restoring divider cell: produces one quotient bit and passes the rest on.
module flog2_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  flog2_pkg::cell_t cell_in,
	output logic             vld_out,
	output flog2_pkg::cell_t cell_out
);
	import flog2_pkg::*;

	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic           ge;
	logic           vld_q;
	cell_t          cell_q;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {cell_in.rem, cell_in.num[Q_W-1]};
	assign diff  = trial - {1'b0, cell_in.den};
	assign ge    = trial >= {1'b0, cell_in.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	// The remainder stays below the divisor, so its top bit is always clear.
	always_ff @(posedge clk) begin
		if (en) begin
			cell_q.rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			cell_q.num <= {cell_in.num[Q_W-2:0], 1'b0};
			cell_q.den <= cell_in.den;
			cell_q.quo <= {cell_in.quo[Q_W-2:0], ge};
			cell_q.acc <= cell_in.acc;
		end
	end

	assign vld_out  = vld_q;
	assign cell_out = cell_q;

endmodule

// ----- design/flog2_out.sv -----
// Output stage: final subtract, rounding shift, saturation and a one-beat skid buffer.
module flog2_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_in,
	input  flog2_pkg::cell_t              cell_in,
	output logic                          en,
	output logic                          in_stall,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [flog2_pkg::OUT_W-1:0] log2_value
);
	import flog2_pkg::*;

	logic signed [ACC_W-1:0] r_val;
	logic signed [ACC_W-1:0] t_val;
	logic [OUT_W-1:0]        res;
	logic                    incoming;
	logic                    out_v_q, skid_v_q;
	logic [OUT_W-1:0]        out_q, skid_q;

	// r = acc - q; the rounding half is already in acc, so the shift rounds.
	assign r_val = $signed(cell_in.acc - ACC_W'(cell_in.quo));
	assign t_val = r_val >>> RND_SHIFT;
	assign res   = sat_out(t_val);

	// The pipeline moves only while the skid register is empty.
	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;
	assign incoming = en && vld_in;

	// Output register with skid: a beat that arrives while the output is held waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && out_stall) begin
			if (incoming) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= incoming;
		end
	end

	// Payload follows the same choices as the valid bits.
	always_ff @(posedge clk) begin
		if (out_v_q && out_stall) begin
			if (incoming) begin
				skid_q <= res;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else if (incoming) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_v_q;
	assign log2_value = $signed(out_q);

endmodule

// ----- design/fast_log2_approximation_core.sv -----
// Top level of the fast log2 approximation core: front end, divider cell chain, output stage.
//
// The block takes one raw single-precision bit pattern per beat on float_bits
// (in_valid / in_stall) and returns an approximate base-2 logarithm on
// log2_value (out_valid / out_stall), two's complement with 16 fraction bits.
// A beat is taken at a rising edge where valid is high and stall is low.
// Every input beat gives exactly one result beat, in order.
// From an accepted beat to out_valid a result passes through three front-end
// stages (multiply, round, sum), 32 divider cells and the output register.
// Throughput is one beat per cycle while in_stall is low; the rate is set by the chain of 32
// restoring divider cells, each of which yields one quotient bit per cycle
// and hands its remainder to the next cell.
// Reset clears every valid bit; no results are pending afterwards.
// When the receiver stalls, the held result stays on the port and one more
// result is caught in a skid register; in_stall then rises and the whole
// pipeline holds until the skid register drains. in_stall comes from a flop.
module fast_log2_approximation_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [flog2_pkg::IN_W-1:0]          float_bits,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [flog2_pkg::OUT_W-1:0]  log2_value
);
	import flog2_pkg::*;

	logic  en;
	logic  chain_vld [NCELLS+1];
	cell_t chain     [NCELLS+1];

	// Front end feeds the first cell.
	flog2_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_in     (in_valid),
		.float_bits (float_bits),
		.vld_out    (chain_vld[0]),
		.cell_out   (chain[0])
	);

	// Divider chain: one quotient bit per cell, most significant first.
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		flog2_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (chain_vld[i]),
			.cell_in  (chain[i]),
			.vld_out  (chain_vld[i+1]),
			.cell_out (chain[i+1])
		);
	end

	// Output stage closes the sum and handles back-pressure.
	flog2_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_in     (chain_vld[NCELLS]),
		.cell_in    (chain[NCELLS]),
		.en         (en),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.log2_value (log2_value)
	);

endmodule
